FILE: rtl/aes_pkg.sv
// ----------------------------------------------------------------------------
// AES-128 package
// Shared types, S-box functions and round helpers for the AES-128 cipher.
// ----------------------------------------------------------------------------
package aes_pkg;

  typedef logic [127:0] blk_t;
  typedef logic [31:0]  word_t;
  typedef logic [7:0]   byte_t;

  typedef struct packed {
    logic load;
    logic decrypt;
    logic first;
    logic last;
    logic [3:0] round;
  } aes_cmd_t;

  localparam logic [0:0] CMD_ENCRYPT = 1'b0;
  localparam logic [0:0] CMD_DECRYPT = 1'b1;

  localparam logic [0:0] REG_KEY_HIGH = 1'b0;
  localparam logic [0:0] REG_KEY_LOW  = 1'b1;

  localparam byte_t RCON_FIRST = 8'h01;

  function automatic byte_t fwd_sbox(input byte_t v);
    byte_t r;
    begin
      case (v)
        8'h00: r=8'h63; 8'h01: r=8'h7c; 8'h02: r=8'h77; 8'h03: r=8'h7b;
        8'h04: r=8'hf2; 8'h05: r=8'h6b; 8'h06: r=8'h6f; 8'h07: r=8'hc5;
        8'h08: r=8'h30; 8'h09: r=8'h01; 8'h0a: r=8'h67; 8'h0b: r=8'h2b;
        8'h0c: r=8'hfe; 8'h0d: r=8'hd7; 8'h0e: r=8'hab; 8'h0f: r=8'h76;
        8'h10: r=8'hca; 8'h11: r=8'h82; 8'h12: r=8'hc9; 8'h13: r=8'h7d;
        8'h14: r=8'hfa; 8'h15: r=8'h59; 8'h16: r=8'h47; 8'h17: r=8'hf0;
        8'h18: r=8'had; 8'h19: r=8'hd4; 8'h1a: r=8'ha2; 8'h1b: r=8'haf;
        8'h1c: r=8'h9c; 8'h1d: r=8'ha4; 8'h1e: r=8'h72; 8'h1f: r=8'hc0;
        8'h20: r=8'hb7; 8'h21: r=8'hfd; 8'h22: r=8'h93; 8'h23: r=8'h26;
        8'h24: r=8'h36; 8'h25: r=8'h3f; 8'h26: r=8'hf7; 8'h27: r=8'hcc;
        8'h28: r=8'h34; 8'h29: r=8'ha5; 8'h2a: r=8'he5; 8'h2b: r=8'hf1;
        8'h2c: r=8'h71; 8'h2d: r=8'hd8; 8'h2e: r=8'h31; 8'h2f: r=8'h15;
        8'h30: r=8'h04; 8'h31: r=8'hc7; 8'h32: r=8'h23; 8'h33: r=8'hc3;
        8'h34: r=8'h18; 8'h35: r=8'h96; 8'h36: r=8'h05; 8'h37: r=8'h9a;
        8'h38: r=8'h07; 8'h39: r=8'h12; 8'h3a: r=8'h80; 8'h3b: r=8'he2;
        8'h3c: r=8'heb; 8'h3d: r=8'h27; 8'h3e: r=8'hb2; 8'h3f: r=8'h75;
        8'h40: r=8'h09; 8'h41: r=8'h83; 8'h42: r=8'h2c; 8'h43: r=8'h1a;
        8'h44: r=8'h1b; 8'h45: r=8'h6e; 8'h46: r=8'h5a; 8'h47: r=8'ha0;
        8'h48: r=8'h52; 8'h49: r=8'h3b; 8'h4a: r=8'hd6; 8'h4b: r=8'hb3;
        8'h4c: r=8'h29; 8'h4d: r=8'he3; 8'h4e: r=8'h2f; 8'h4f: r=8'h84;
        8'h50: r=8'h53; 8'h51: r=8'hd1; 8'h52: r=8'h00; 8'h53: r=8'hed;
        8'h54: r=8'h20; 8'h55: r=8'hfc; 8'h56: r=8'hb1; 8'h57: r=8'h5b;
        8'h58: r=8'h6a; 8'h59: r=8'hcb; 8'h5a: r=8'hbe; 8'h5b: r=8'h39;
        8'h5c: r=8'h4a; 8'h5d: r=8'h4c; 8'h5e: r=8'h58; 8'h5f: r=8'hcf;
        8'h60: r=8'hd0; 8'h61: r=8'hef; 8'h62: r=8'haa; 8'h63: r=8'hfb;
        8'h64: r=8'h43; 8'h65: r=8'h4d; 8'h66: r=8'h33; 8'h67: r=8'h85;
        8'h68: r=8'h45; 8'h69: r=8'hf9; 8'h6a: r=8'h02; 8'h6b: r=8'h7f;
        8'h6c: r=8'h50; 8'h6d: r=8'h3c; 8'h6e: r=8'h9f; 8'h6f: r=8'ha8;
        8'h70: r=8'h51; 8'h71: r=8'ha3; 8'h72: r=8'h40; 8'h73: r=8'h8f;
        8'h74: r=8'h92; 8'h75: r=8'h9d; 8'h76: r=8'h38; 8'h77: r=8'hf5;
        8'h78: r=8'hbc; 8'h79: r=8'hb6; 8'h7a: r=8'hda; 8'h7b: r=8'h21;
        8'h7c: r=8'h10; 8'h7d: r=8'hff; 8'h7e: r=8'hf3; 8'h7f: r=8'hd2;
        8'h80: r=8'hcd; 8'h81: r=8'h0c; 8'h82: r=8'h13; 8'h83: r=8'hec;
        8'h84: r=8'h5f; 8'h85: r=8'h97; 8'h86: r=8'h44; 8'h87: r=8'h17;
        8'h88: r=8'hc4; 8'h89: r=8'ha7; 8'h8a: r=8'h7e; 8'h8b: r=8'h3d;
        8'h8c: r=8'h64; 8'h8d: r=8'h5d; 8'h8e: r=8'h19; 8'h8f: r=8'h73;
        8'h90: r=8'h60; 8'h91: r=8'h81; 8'h92: r=8'h4f; 8'h93: r=8'hdc;
        8'h94: r=8'h22; 8'h95: r=8'h2a; 8'h96: r=8'h90; 8'h97: r=8'h88;
        8'h98: r=8'h46; 8'h99: r=8'hee; 8'h9a: r=8'hb8; 8'h9b: r=8'h14;
        8'h9c: r=8'hde; 8'h9d: r=8'h5e; 8'h9e: r=8'h0b; 8'h9f: r=8'hdb;
        8'ha0: r=8'he0; 8'ha1: r=8'h32; 8'ha2: r=8'h3a; 8'ha3: r=8'h0a;
        8'ha4: r=8'h49; 8'ha5: r=8'h06; 8'ha6: r=8'h24; 8'ha7: r=8'h5c;
        8'ha8: r=8'hc2; 8'ha9: r=8'hd3; 8'haa: r=8'hac; 8'hab: r=8'h62;
        8'hac: r=8'h91; 8'had: r=8'h95; 8'hae: r=8'he4; 8'haf: r=8'h79;
        8'hb0: r=8'he7; 8'hb1: r=8'hc8; 8'hb2: r=8'h37; 8'hb3: r=8'h6d;
        8'hb4: r=8'h8d; 8'hb5: r=8'hd5; 8'hb6: r=8'h4e; 8'hb7: r=8'ha9;
        8'hb8: r=8'h6c; 8'hb9: r=8'h56; 8'hba: r=8'hf4; 8'hbb: r=8'hea;
        8'hbc: r=8'h65; 8'hbd: r=8'h7a; 8'hbe: r=8'hae; 8'hbf: r=8'h08;
        8'hc0: r=8'hba; 8'hc1: r=8'h78; 8'hc2: r=8'h25; 8'hc3: r=8'h2e;
        8'hc4: r=8'h1c; 8'hc5: r=8'ha6; 8'hc6: r=8'hb4; 8'hc7: r=8'hc6;
        8'hc8: r=8'he8; 8'hc9: r=8'hdd; 8'hca: r=8'h74; 8'hcb: r=8'h1f;
        8'hcc: r=8'h4b; 8'hcd: r=8'hbd; 8'hce: r=8'h8b; 8'hcf: r=8'h8a;
        8'hd0: r=8'h70; 8'hd1: r=8'h3e; 8'hd2: r=8'hb5; 8'hd3: r=8'h66;
        8'hd4: r=8'h48; 8'hd5: r=8'h03; 8'hd6: r=8'hf6; 8'hd7: r=8'h0e;
        8'hd8: r=8'h61; 8'hd9: r=8'h35; 8'hda: r=8'h57; 8'hdb: r=8'hb9;
        8'hdc: r=8'h86; 8'hdd: r=8'hc1; 8'hde: r=8'h1d; 8'hdf: r=8'h9e;
        8'he0: r=8'he1; 8'he1: r=8'hf8; 8'he2: r=8'h98; 8'he3: r=8'h11;
        8'he4: r=8'h69; 8'he5: r=8'hd9; 8'he6: r=8'h8e; 8'he7: r=8'h94;
        8'he8: r=8'h9b; 8'he9: r=8'h1e; 8'hea: r=8'h87; 8'heb: r=8'he9;
        8'hec: r=8'hce; 8'hed: r=8'h55; 8'hee: r=8'h28; 8'hef: r=8'hdf;
        8'hf0: r=8'h8c; 8'hf1: r=8'ha1; 8'hf2: r=8'h89; 8'hf3: r=8'h0d;
        8'hf4: r=8'hbf; 8'hf5: r=8'he6; 8'hf6: r=8'h42; 8'hf7: r=8'h68;
        8'hf8: r=8'h41; 8'hf9: r=8'h99; 8'hfa: r=8'h2d; 8'hfb: r=8'h0f;
        8'hfc: r=8'hb0; 8'hfd: r=8'h54; 8'hfe: r=8'hbb; default: r=8'h16;
      endcase
      return r;
    end
  endfunction

  function automatic byte_t inv_sbox(input byte_t v);
    byte_t r;
    begin
      case (v)
        8'h00: r=8'h52; 8'h01: r=8'h09; 8'h02: r=8'h6a; 8'h03: r=8'hd5;
        8'h04: r=8'h30; 8'h05: r=8'h36; 8'h06: r=8'ha5; 8'h07: r=8'h38;
        8'h08: r=8'hbf; 8'h09: r=8'h40; 8'h0a: r=8'ha3; 8'h0b: r=8'h9e;
        8'h0c: r=8'h81; 8'h0d: r=8'hf3; 8'h0e: r=8'hd7; 8'h0f: r=8'hfb;
        8'h10: r=8'h7c; 8'h11: r=8'he3; 8'h12: r=8'h39; 8'h13: r=8'h82;
        8'h14: r=8'h9b; 8'h15: r=8'h2f; 8'h16: r=8'hff; 8'h17: r=8'h87;
        8'h18: r=8'h34; 8'h19: r=8'h8e; 8'h1a: r=8'h43; 8'h1b: r=8'h44;
        8'h1c: r=8'hc4; 8'h1d: r=8'hde; 8'h1e: r=8'he9; 8'h1f: r=8'hcb;
        8'h20: r=8'h54; 8'h21: r=8'h7b; 8'h22: r=8'h94; 8'h23: r=8'h32;
        8'h24: r=8'ha6; 8'h25: r=8'hc2; 8'h26: r=8'h23; 8'h27: r=8'h3d;
        8'h28: r=8'hee; 8'h29: r=8'h4c; 8'h2a: r=8'h95; 8'h2b: r=8'h0b;
        8'h2c: r=8'h42; 8'h2d: r=8'hfa; 8'h2e: r=8'hc3; 8'h2f: r=8'h4e;
        8'h30: r=8'h08; 8'h31: r=8'h2e; 8'h32: r=8'ha1; 8'h33: r=8'h66;
        8'h34: r=8'h28; 8'h35: r=8'hd9; 8'h36: r=8'h24; 8'h37: r=8'hb2;
        8'h38: r=8'h76; 8'h39: r=8'h5b; 8'h3a: r=8'ha2; 8'h3b: r=8'h49;
        8'h3c: r=8'h6d; 8'h3d: r=8'h8b; 8'h3e: r=8'hd1; 8'h3f: r=8'h25;
        8'h40: r=8'h72; 8'h41: r=8'hf8; 8'h42: r=8'hf6; 8'h43: r=8'h64;
        8'h44: r=8'h86; 8'h45: r=8'h68; 8'h46: r=8'h98; 8'h47: r=8'h16;
        8'h48: r=8'hd4; 8'h49: r=8'ha4; 8'h4a: r=8'h5c; 8'h4b: r=8'hcc;
        8'h4c: r=8'h5d; 8'h4d: r=8'h65; 8'h4e: r=8'hb6; 8'h4f: r=8'h92;
        8'h50: r=8'h6c; 8'h51: r=8'h70; 8'h52: r=8'h48; 8'h53: r=8'h50;
        8'h54: r=8'hfd; 8'h55: r=8'hed; 8'h56: r=8'hb9; 8'h57: r=8'hda;
        8'h58: r=8'h5e; 8'h59: r=8'h15; 8'h5a: r=8'h46; 8'h5b: r=8'h57;
        8'h5c: r=8'ha7; 8'h5d: r=8'h8d; 8'h5e: r=8'h9d; 8'h5f: r=8'h84;
        8'h60: r=8'h90; 8'h61: r=8'hd8; 8'h62: r=8'hab; 8'h63: r=8'h00;
        8'h64: r=8'h8c; 8'h65: r=8'hbc; 8'h66: r=8'hd3; 8'h67: r=8'h0a;
        8'h68: r=8'hf7; 8'h69: r=8'he4; 8'h6a: r=8'h58; 8'h6b: r=8'h05;
        8'h6c: r=8'hb8; 8'h6d: r=8'hb3; 8'h6e: r=8'h45; 8'h6f: r=8'h06;
        8'h70: r=8'hd0; 8'h71: r=8'h2c; 8'h72: r=8'h1e; 8'h73: r=8'h8f;
        8'h74: r=8'hca; 8'h75: r=8'h3f; 8'h76: r=8'h0f; 8'h77: r=8'h02;
        8'h78: r=8'hc1; 8'h79: r=8'haf; 8'h7a: r=8'hbd; 8'h7b: r=8'h03;
        8'h7c: r=8'h01; 8'h7d: r=8'h13; 8'h7e: r=8'h8a; 8'h7f: r=8'h6b;
        8'h80: r=8'h3a; 8'h81: r=8'h91; 8'h82: r=8'h11; 8'h83: r=8'h41;
        8'h84: r=8'h4f; 8'h85: r=8'h67; 8'h86: r=8'hdc; 8'h87: r=8'hea;
        8'h88: r=8'h97; 8'h89: r=8'hf2; 8'h8a: r=8'hcf; 8'h8b: r=8'hce;
        8'h8c: r=8'hf0; 8'h8d: r=8'hb4; 8'h8e: r=8'he6; 8'h8f: r=8'h73;
        8'h90: r=8'h96; 8'h91: r=8'hac; 8'h92: r=8'h74; 8'h93: r=8'h22;
        8'h94: r=8'he7; 8'h95: r=8'had; 8'h96: r=8'h35; 8'h97: r=8'h85;
        8'h98: r=8'he2; 8'h99: r=8'hf9; 8'h9a: r=8'h37; 8'h9b: r=8'he8;
        8'h9c: r=8'h1c; 8'h9d: r=8'h75; 8'h9e: r=8'hdf; 8'h9f: r=8'h6e;
        8'ha0: r=8'h47; 8'ha1: r=8'hf1; 8'ha2: r=8'h1a; 8'ha3: r=8'h71;
        8'ha4: r=8'h1d; 8'ha5: r=8'h29; 8'ha6: r=8'hc5; 8'ha7: r=8'h89;
        8'ha8: r=8'h6f; 8'ha9: r=8'hb7; 8'haa: r=8'h62; 8'hab: r=8'h0e;
        8'hac: r=8'haa; 8'had: r=8'h18; 8'hae: r=8'hbe; 8'haf: r=8'h1b;
        8'hb0: r=8'hfc; 8'hb1: r=8'h56; 8'hb2: r=8'h3e; 8'hb3: r=8'h4b;
        8'hb4: r=8'hc6; 8'hb5: r=8'hd2; 8'hb6: r=8'h79; 8'hb7: r=8'h20;
        8'hb8: r=8'h9a; 8'hb9: r=8'hdb; 8'hba: r=8'hc0; 8'hbb: r=8'hfe;
        8'hbc: r=8'h78; 8'hbd: r=8'hcd; 8'hbe: r=8'h5a; 8'hbf: r=8'hf4;
        8'hc0: r=8'h1f; 8'hc1: r=8'hdd; 8'hc2: r=8'ha8; 8'hc3: r=8'h33;
        8'hc4: r=8'h88; 8'hc5: r=8'h07; 8'hc6: r=8'hc7; 8'hc7: r=8'h31;
        8'hc8: r=8'hb1; 8'hc9: r=8'h12; 8'hca: r=8'h10; 8'hcb: r=8'h59;
        8'hcc: r=8'h27; 8'hcd: r=8'h80; 8'hce: r=8'hec; 8'hcf: r=8'h5f;
        8'hd0: r=8'h60; 8'hd1: r=8'h51; 8'hd2: r=8'h7f; 8'hd3: r=8'ha9;
        8'hd4: r=8'h19; 8'hd5: r=8'hb5; 8'hd6: r=8'h4a; 8'hd7: r=8'h0d;
        8'hd8: r=8'h2d; 8'hd9: r=8'he5; 8'hda: r=8'h7a; 8'hdb: r=8'h9f;
        8'hdc: r=8'h93; 8'hdd: r=8'hc9; 8'hde: r=8'h9c; 8'hdf: r=8'hef;
        8'he0: r=8'ha0; 8'he1: r=8'he0; 8'he2: r=8'h3b; 8'he3: r=8'h4d;
        8'he4: r=8'hae; 8'he5: r=8'h2a; 8'he6: r=8'hf5; 8'he7: r=8'hb0;
        8'he8: r=8'hc8; 8'he9: r=8'heb; 8'hea: r=8'hbb; 8'heb: r=8'h3c;
        8'hec: r=8'h83; 8'hed: r=8'h53; 8'hee: r=8'h99; 8'hef: r=8'h61;
        8'hf0: r=8'h17; 8'hf1: r=8'h2b; 8'hf2: r=8'h04; 8'hf3: r=8'h7e;
        8'hf4: r=8'hba; 8'hf5: r=8'h77; 8'hf6: r=8'hd6; 8'hf7: r=8'h26;
        8'hf8: r=8'he1; 8'hf9: r=8'h69; 8'hfa: r=8'h14; 8'hfb: r=8'h63;
        8'hfc: r=8'h55; 8'hfd: r=8'h21; 8'hfe: r=8'h0c; default: r=8'h7d;
      endcase
      return r;
    end
  endfunction

  function automatic byte_t xtime(input byte_t v);
    return v[7] ? ({v[6:0], 1'b0} ^ 8'h1b) : {v[6:0], 1'b0};
  endfunction

  // Byte k of a block sits at bits 127-8k down to 120-8k.
  function automatic byte_t get_byte(input blk_t s, input int k);
    return s[127 - 8*k -: 8];
  endfunction

  function automatic blk_t sub_shift(input blk_t s, input logic inverse);
    blk_t t;
    byte_t v;
    int src;
    begin
      t = '0;
      for (int c = 0; c < 4; c++) begin
        for (int r = 0; r < 4; r++) begin
          src = inverse ? ((c - r + 4) & 3) : ((c + r) & 3);
          v = get_byte(s, 4*src + r);
          t[127 - 8*(4*c + r) -: 8] = inverse ? inv_sbox(v) : fwd_sbox(v);
        end
      end
      return t;
    end
  endfunction

  function automatic blk_t mix_columns(input blk_t s);
    blk_t t;
    byte_t a0, a1, a2, a3, al;
    begin
      t = '0;
      for (int c = 0; c < 4; c++) begin
        a0 = get_byte(s, 4*c);
        a1 = get_byte(s, 4*c + 1);
        a2 = get_byte(s, 4*c + 2);
        a3 = get_byte(s, 4*c + 3);
        al = a0 ^ a1 ^ a2 ^ a3;
        t[127 - 32*c -: 32] = {a0 ^ al ^ xtime(a0 ^ a1), a1 ^ al ^ xtime(a1 ^ a2),
                               a2 ^ al ^ xtime(a2 ^ a3), a3 ^ al ^ xtime(a3 ^ a0)};
      end
      return t;
    end
  endfunction

  function automatic blk_t inv_mix_columns(input blk_t s);
    blk_t t;
    byte_t u, v;
    begin
      t = s;
      for (int c = 0; c < 4; c++) begin
        u = xtime(xtime(get_byte(s, 4*c) ^ get_byte(s, 4*c + 2)));
        v = xtime(xtime(get_byte(s, 4*c + 1) ^ get_byte(s, 4*c + 3)));
        t[127 - 32*c -: 32] = s[127 - 32*c -: 32] ^ {u, v, u, v};
      end
      return mix_columns(t);
    end
  endfunction

  // One forward key schedule step: round key n from round key n-1.
  function automatic blk_t key_fwd(input blk_t k, input byte_t rc);
    word_t w0, w1, w2, w3, t;
    begin
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      t = {fwd_sbox(w3[23:16]) ^ rc, fwd_sbox(w3[15:8]), fwd_sbox(w3[7:0]),
           fwd_sbox(w3[31:24])};
      w0 = w0 ^ t; w1 = w1 ^ w0; w2 = w2 ^ w1; w3 = w3 ^ w2;
      return {w0, w1, w2, w3};
    end
  endfunction

  // Inverse step: round key n-1 from round key n, rc being round n's constant.
  function automatic blk_t key_inv(input blk_t k, input byte_t rc);
    word_t w0, w1, w2, w3, t;
    begin
      w0 = k[127:96]; w1 = k[95:64]; w2 = k[63:32]; w3 = k[31:0];
      w3 = w3 ^ w2; w2 = w2 ^ w1; w1 = w1 ^ w0;
      t = {fwd_sbox(w3[23:16]) ^ rc, fwd_sbox(w3[15:8]), fwd_sbox(w3[7:0]),
           fwd_sbox(w3[31:24])};
      w0 = w0 ^ t;
      return {w0, w1, w2, w3};
    end
  endfunction

  function automatic byte_t inv_xtime(input byte_t v);
    return v[0] ? ({1'b0, v[7:1]} ^ 8'h8d) : {1'b0, v[7:1]};
  endfunction

endpackage

FILE: rtl/aes128_block_cipher.sv
// ----------------------------------------------------------------------------
// AES-128 block cipher
// ECB encryption and decryption of 128-bit blocks under a configured key.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Encryption runs the
// ten rounds on the shared round unit after the initial key addition, with
// round keys derived on the fly. For decryption the key schedule is first
// walked forward to the last round key, then run backward alongside the
// rounds. A new request can be taken while out_valid is high.
// out_valid is high for exactly one cycle and the receiver cannot stall it.
module aes128_block_cipher (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [63:0] cfg_data,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [63:0] in_block_high,
  input  logic [63:0] in_block_low,
  output logic        out_valid,
  output logic [63:0] out_result_high,
  output logic [63:0] out_result_low
);

  logic [63:0]       key_high_r, key_low_r;
  logic              done;
  logic [127:0]      result;
  logic              valid_r;
  logic [127:0]      res_r;
  aes_pkg::aes_cmd_t cmd;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_high_r <= '0;
      key_low_r  <= '0;
      valid_r    <= 1'b0;
    end else begin
      valid_r <= done;
      if (cfg_we) begin
        unique case (cfg_index)
          aes_pkg::REG_KEY_HIGH: key_high_r <= cfg_data;
          aes_pkg::REG_KEY_LOW:  key_low_r  <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (done) res_r <= result;
  end

  aes_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .in_command (in_command),
    .busy       (busy),
    .cmd        (cmd),
    .done       (done)
  );

  aes_dp u_dp (
    .clk           (clk),
    .cmd           (cmd),
    .key_high      (key_high_r),
    .key_low       (key_low_r),
    .in_block_high (in_block_high),
    .in_block_low  (in_block_low),
    .result        (result)
  );

  assign out_valid       = valid_r;
  assign out_result_high = res_r[127:64];
  assign out_result_low  = res_r[63:0];

endmodule

FILE: rtl/aes_ctrl.sv
// ----------------------------------------------------------------------------
// AES-128 controller
// Sequences key preparation for decryption and the ten rounds, and issues datapath commands.
// ----------------------------------------------------------------------------
module aes_ctrl (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  logic             in_command,
  output logic             busy,
  output aes_pkg::aes_cmd_t cmd,
  output logic             done
);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_KEY   = 2'd1;
  localparam logic [1:0] ST_ROUND = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic [3:0] cnt_r, cnt_nxt;
  logic       dec_r, dec_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    dec_nxt   = dec_r;
    cmd       = '0;
    cmd.decrypt = dec_r;
    cmd.round   = cnt_r;
    done      = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.load    = 1'b1;
          cmd.decrypt = in_command;
          dec_nxt     = in_command;
          cnt_nxt     = 4'd1;
          state_nxt   = in_command ? ST_KEY : ST_ROUND;
        end
      end
      ST_KEY: begin
        // Walks the schedule forward to the last round key; round zero marks a
        // plain schedule step, and the tenth step also starts the first round.
        if (cnt_r == 4'd10) begin
          cmd.first = 1'b1;
          cnt_nxt   = 4'd1;
          state_nxt = ST_ROUND;
        end else begin
          cmd.round = 4'd0;
          cnt_nxt   = cnt_r + 4'd1;
        end
      end
      ST_ROUND: begin
        cmd.last = (cnt_r == 4'd10);
        if (cnt_r == 4'd10) begin
          done      = 1'b1;
          state_nxt = ST_IDLE;
        end else begin
          cnt_nxt = cnt_r + 4'd1;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      dec_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      dec_r   <= dec_nxt;
    end
  end

  a_done_in_round: assert property (@(posedge clk) disable iff (!rst_n)
    done |-> state_r == ST_ROUND && cnt_r == 4'd10)
    else $error("done outside last round");
  a_idle_after_done: assert property (@(posedge clk) disable iff (!rst_n)
    done |=> state_r == ST_IDLE)
    else $error("no return to idle");
  a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> cnt_r >= 4'd1 && cnt_r <= 4'd10)
    else $error("counter out of range");

endmodule

FILE: rtl/aes_dp.sv
// ----------------------------------------------------------------------------
// AES-128 datapath
// State register, shared round unit and on-the-fly round key register.
// ----------------------------------------------------------------------------
module aes_dp (
  input  logic              clk,
  input  aes_pkg::aes_cmd_t cmd,
  input  logic [63:0]       key_high,
  input  logic [63:0]       key_low,
  input  logic [63:0]       in_block_high,
  input  logic [63:0]       in_block_low,
  output logic [127:0]      result
);

  aes_pkg::blk_t  st_r, st_nxt, rk_r, rk_nxt, key_in, blk_in, fwd_k, inv_k, rs;
  aes_pkg::byte_t rc_r, rc_nxt;

  assign key_in = {key_high, key_low};
  assign blk_in = {in_block_high, in_block_low};
  assign fwd_k  = aes_pkg::key_fwd(rk_r, rc_r);
  assign inv_k  = aes_pkg::key_inv(rk_r, rc_r);

  always_comb begin
    st_nxt = st_r;
    rk_nxt = rk_r;
    rc_nxt = rc_r;
    rs     = '0;
    result = '0;
    if (cmd.load) begin
      rk_nxt = key_in;
      rc_nxt = aes_pkg::RCON_FIRST;
      st_nxt = cmd.decrypt ? blk_in : (blk_in ^ key_in);
    end else if (!cmd.decrypt) begin
      rs = aes_pkg::sub_shift(st_r, 1'b0);
      if (!cmd.last) rs = aes_pkg::mix_columns(rs);
      st_nxt = rs ^ fwd_k;
      result = st_nxt;
      rk_nxt = fwd_k;
      rc_nxt = aes_pkg::xtime(rc_r);
    end else if (cmd.round == 4'd0) begin
      // Key walk: advance forward toward round key 9.
      rk_nxt = fwd_k;
      rc_nxt = aes_pkg::xtime(rc_r);
    end else if (cmd.first) begin
      // The last forward step yields round key 10; add it before round 10.
      // rk_r keeps round key 9 and rc steps back to round 9's constant.
      st_nxt = aes_pkg::sub_shift(st_r ^ fwd_k, 1'b1);
      rc_nxt = aes_pkg::inv_xtime(rc_r);
    end else if (cmd.last) begin
      st_nxt = st_r ^ rk_r;
      result = st_nxt;
    end else begin
      rs = aes_pkg::inv_mix_columns(st_r ^ rk_r);
      st_nxt = aes_pkg::sub_shift(rs, 1'b1);
      rk_nxt = inv_k;
      rc_nxt = aes_pkg::inv_xtime(rc_r);
    end
  end

  always_ff @(posedge clk) begin
    st_r <= st_nxt;
    rk_r <= rk_nxt;
    rc_r <= rc_nxt;
  end

endmodule
